// File: design/bavg_pkg.sv
// bavg_pkg: shared types and constants of the block average downsampler
// item record passed from the front end to the back end through the queue
// no dependencies
`timescale 1ns / 1ps

package bavg_pkg;

	localparam int PIX_W       = 8;
	localparam int IDX_W       = 6;   // holds block indexes up to 63
	localparam int OUT_IDX_W   = 4;
	localparam int SUM_W       = 25;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 40;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic KIND_BLOCK = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             start;
		logic             run_first;
		logic             run_last;
		logic             block_done;
		logic             frame_done;
		logic [IDX_W-1:0] bcol;
		logic [IDX_W-1:0] brow;
	} item_t;

endpackage

// File: design/bavg_ram.sv
// bavg_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/bavg_fifo.sv
// bavg_fifo: short queue of classified pixel items between front and back end
// depends on bavg_pkg
`timescale 1ns / 1ps

module bavg_fifo
	import bavg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	item_t               buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/bavg_front.sv
// bavg_front: accepts pixels, tracks the raster position and classifies each pixel
// depends on bavg_pkg; feeds bavg_fifo
`timescale 1ns / 1ps

module bavg_front
	import bavg_pkg::*;
#(
	parameter int BLOCK_SIZE    = 20,
	parameter int BLOCKS_ACROSS = 16,
	parameter int BLOCKS_DOWN   = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 q_push,
	output item_t                q_item,
	input  logic                 q_full
);

	localparam int IW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

	logic [IW-1:0]    xin_q, yin_q;
	logic [IDX_W-1:0] bcol_q, brow_q;
	logic [IW-1:0]    cur_x, cur_y;
	logic [IDX_W-1:0] cur_bc, cur_br;
	logic             last_x, last_y, last_bc, last_br;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		// frame start restarts the position before the pixel is classified
		cur_x  = s_tuser ? '0 : xin_q;
		cur_y  = s_tuser ? '0 : yin_q;
		cur_bc = s_tuser ? '0 : bcol_q;
		cur_br = s_tuser ? '0 : brow_q;
		last_x  = (cur_x == IW'(BLOCK_SIZE - 1));
		last_y  = (cur_y == IW'(BLOCK_SIZE - 1));
		last_bc = (cur_bc == IDX_W'(BLOCKS_ACROSS - 1));
		last_br = (cur_br == IDX_W'(BLOCKS_DOWN - 1));
		q_item.pix        = s_tdata[PIX_W-1:0];
		q_item.start      = s_tuser;
		q_item.run_first  = (cur_x == '0);
		q_item.run_last   = last_x;
		q_item.block_done = last_x && last_y;
		q_item.frame_done = last_x && last_y && last_bc && last_br;
		q_item.bcol       = cur_bc;
		q_item.brow       = cur_br;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xin_q  <= '0;
			yin_q  <= '0;
			bcol_q <= '0;
			brow_q <= '0;
		end else if (q_push) begin
			if (!last_x) begin
				xin_q  <= cur_x + 1'b1;
				bcol_q <= cur_bc;
				yin_q  <= cur_y;
				brow_q <= cur_br;
			end else if (!last_bc) begin
				xin_q  <= '0;
				bcol_q <= cur_bc + 1'b1;
				yin_q  <= cur_y;
				brow_q <= cur_br;
			end else if (!last_y) begin
				xin_q  <= '0;
				bcol_q <= '0;
				yin_q  <= cur_y + 1'b1;
				brow_q <= cur_br;
			end else begin
				xin_q  <= '0;
				bcol_q <= '0;
				yin_q  <= '0;
				brow_q <= last_br ? '0 : cur_br + 1'b1;
			end
		end
	end

endmodule

// File: design/bavg_back.sv
// bavg_back: accumulates column runs into the block sum memory and the frame total,
// emits block and frame results through an output register
// depends on bavg_pkg and bavg_ram
`timescale 1ns / 1ps

module bavg_back
	import bavg_pkg::*;
#(
	parameter int BLOCK_SIZE    = 20,
	parameter int BLOCKS_ACROSS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  item_t                q_item,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_kind,
	output logic                 m_last,
	output logic [OUT_IDX_W-1:0] m_row,
	output logic [OUT_IDX_W-1:0] m_col,
	output logic [SUM_W-1:0]     m_sum
);

	localparam int AW = (BLOCKS_ACROSS > 1) ? $clog2(BLOCKS_ACROSS) : 1;
	localparam int SW = $clog2(BLOCK_SIZE * BLOCK_SIZE * 255 + 1);

	item_t                    item_s1;
	logic                     valid_s1;
	logic                     fwd_s1;
	logic [SW-1:0]            fwd_data_s1;
	logic                     phase_q;
	logic [SW-1:0]            acc_q;
	logic [SUM_W-1:0]         ft_q;
	logic [BLOCKS_ACROSS-1:0] bvalid_q;
	logic [BLOCKS_ACROSS-1:0] bvalid_d;

	logic [SW-1:0]    rd_data;
	logic [SW-1:0]    base;
	logic [SW-1:0]    blk_sum;
	logic [SUM_W:0]   ft_add;
	logic [SUM_W-1:0] ft_sum;
	logic [AW-1:0]    addr_s1;
	logic             out_free, emit, leave, wr_en;

	assign addr_s1 = item_s1.bcol[AW-1:0];

	always_comb begin
		// a run starts from the stored column sum, the sum just written back or zero
		priority if (item_s1.start) begin
			base = '0;
		end else if (fwd_s1) begin
			base = fwd_data_s1;
		end else if (bvalid_q[addr_s1]) begin
			base = rd_data;
		end else begin
			base = '0;
		end
		blk_sum = (item_s1.run_first ? base : acc_q) + SW'(item_s1.pix);
		ft_add  = {1'b0, (item_s1.start ? SUM_W'(0) : ft_q)} + (SUM_W + 1)'(item_s1.pix);
		ft_sum  = ft_add[SUM_W] ? '1 : ft_add[SUM_W-1:0];

		out_free = !m_tvalid || m_tready;
		emit     = valid_s1 && item_s1.block_done && out_free;
		leave    = valid_s1 && (!item_s1.block_done ||
			(out_free && (phase_q || !item_s1.frame_done)));
		q_pop    = q_valid && (!valid_s1 || leave);
		wr_en    = leave && item_s1.run_last && !item_s1.block_done;

		bvalid_d = item_s1.start ? '0 : bvalid_q;
		if (item_s1.block_done) begin
			bvalid_d[addr_s1] = 1'b0;
		end else if (item_s1.run_last) begin
			bvalid_d[addr_s1] = 1'b1;
		end
	end

	bavg_ram #(
		.WIDTH (SW),
		.DEPTH (BLOCKS_ACROSS),
		.AW    (AW)
	) u_sums (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (blk_sum),
		.rd_en   (q_pop),
		.rd_addr (q_item.bcol[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1     <= q_item;
			fwd_data_s1 <= item_s1.block_done ? '0 : blk_sum;
		end
		if (leave) begin
			acc_q <= blk_sum;
		end
		if (emit) begin
			if (phase_q) begin
				m_kind <= KIND_FRAME;
				m_last <= 1'b1;
				m_row  <= '0;
				m_col  <= '0;
				m_sum  <= ft_sum;
			end else begin
				m_kind <= KIND_BLOCK;
				m_last <= !item_s1.frame_done;
				m_row  <= item_s1.brow[OUT_IDX_W-1:0];
				m_col  <= item_s1.bcol[OUT_IDX_W-1:0];
				m_sum  <= SUM_W'(blk_sum);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			phase_q  <= 1'b0;
			ft_q     <= '0;
			bvalid_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= leave && item_s1.run_last &&
					(addr_s1 == q_item.bcol[AW-1:0]);
			end else if (leave) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
			if (leave) begin
				phase_q  <= 1'b0;
				ft_q     <= item_s1.frame_done ? '0 : ft_sum;
				bvalid_q <= bvalid_d;
			end else if (emit) begin
				phase_q <= 1'b1;
			end
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	a_phase_frame: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (valid_s1 && item_s1.frame_done))
		else $error("second result phase without a frame end item");

	a_fwd_held: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("forwarded sum with empty stage");

	a_frame_two: assert property (@(posedge clk) disable iff (!arst_n)
		(leave && item_s1.frame_done) |-> phase_q)
		else $error("frame end item left before its frame result");

endmodule

// File: design/block_average_downsampler_top.sv
// Block average downsampler: 8-bit grey pixels in raster order; the frame is
// BLOCKS_ACROSS by BLOCKS_DOWN blocks of BLOCK_SIZE square pixels. Each block's
// last pixel yields that block's exact pixel sum (tuser 0); the frame's last pixel
// yields the block sum and then the frame sum (tuser 1, saturating at 2^25-1),
// tlast marking the last result of a pixel. tuser on the input restarts the frame.
// One pixel is taken per clock while the queue has room; a frame's last pixel
// holds the back end for both results, which the four-entry queue absorbs. Column
// sums live in a small ram read when an item leaves the queue; valid bits clear it
// at once on reset and frame start, so no clearing pass is needed.
// depends on bavg_pkg, bavg_front, bavg_fifo, bavg_back, bavg_ram
`timescale 1ns / 1ps

module block_average_downsampler_top
	import bavg_pkg::*;
#(
	parameter int BLOCK_SIZE    = 20,
	parameter int BLOCKS_ACROSS = 16,
	parameter int BLOCKS_DOWN   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] pixel
	input  logic                  s_tuser,   // frame_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] block_row, [7:4] block_col,
	                                         // [32:8] pixel_sum, rest zero
	output logic                  m_tuser,   // kind
	output logic                  m_tlast    // last
);

	logic                 q_push, q_full, q_valid, q_pop;
	item_t                push_item, head_item;
	logic [OUT_IDX_W-1:0] row, col;
	logic [SUM_W-1:0]     sum;

	bavg_front #(
		.BLOCK_SIZE    (BLOCK_SIZE),
		.BLOCKS_ACROSS (BLOCKS_ACROSS),
		.BLOCKS_DOWN   (BLOCKS_DOWN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_item   (push_item),
		.q_full   (q_full)
	);

	bavg_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (head_item)
	);

	bavg_back #(
		.BLOCK_SIZE    (BLOCK_SIZE),
		.BLOCKS_ACROSS (BLOCKS_ACROSS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_kind   (m_tuser),
		.m_last   (m_tlast),
		.m_row    (row),
		.m_col    (col),
		.m_sum    (sum)
	);

	assign m_tdata = {(OUT_DATA_W - SUM_W - 2 * OUT_IDX_W)'(0), sum, col, row};

endmodule

// File: bench/bavg_scoreboard_pkg.sv
// bavg_scoreboard_pkg: frame geometry and the block sum checker used by tb_top
// predicts block and frame sums from accepted pixels and checks each result in order
// depends on bavg_pkg
`timescale 1ns / 1ps

package bavg_scoreboard_pkg;
	import bavg_pkg::*;

	localparam int BLK_SIZE   = 20;
	localparam int BLK_ACROSS = 16;
	localparam int BLK_DOWN   = 12;
	localparam int FRAME_W    = BLK_SIZE * BLK_ACROSS;
	localparam int FRAME_H    = BLK_SIZE * BLK_DOWN;

	localparam int ROW_LO = 0;
	localparam int COL_LO = OUT_IDX_W;
	localparam int SUM_LO = 2 * OUT_IDX_W;
	localparam int PAD_LO = SUM_LO + SUM_W;

	typedef struct {
		logic                 kind;
		logic [OUT_IDX_W-1:0] brow;
		logic [OUT_IDX_W-1:0] bcol;
		logic [SUM_W-1:0]     sum;
		logic                 last;
	} pixel_sum_t;

	class block_sum_checker;
		logic [8:0]       col_pos;
		logic [7:0]       row_pos;
		logic [16:0]      col_sums [BLK_ACROSS];
		logic [SUM_W-1:0] frame_sum;
		pixel_sum_t       sums_due [$];
		int               errors;

		function new();
			errors = 0;
			restart_frame();
		endfunction

		function void restart_frame();
			col_pos   = '0;
			row_pos   = '0;
			frame_sum = '0;
			foreach (col_sums[i])
				col_sums[i] = '0;
		endfunction

		function int pending();
			return sums_due.size();
		endfunction

		function void accumulate_pixel(logic [PIX_W-1:0] pix, logic frame_start);
			int unsigned bcol;
			int unsigned brow;
			logic [SUM_W:0] wide;
			logic block_end;
			logic frame_end;
			pixel_sum_t r;
			if (frame_start)
				restart_frame();
			bcol = col_pos / BLK_SIZE;
			brow = row_pos / BLK_SIZE;
			if (bcol >= BLK_ACROSS)
				bcol = BLK_ACROSS - 1;
			col_sums[bcol] = col_sums[bcol] + pix;
			// frame sum saturates instead of wrapping
			wide = {1'b0, frame_sum} + pix;
			frame_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
			block_end = (col_pos % BLK_SIZE == BLK_SIZE - 1) && (row_pos % BLK_SIZE == BLK_SIZE - 1);
			frame_end = (col_pos == FRAME_W - 1) && (row_pos == FRAME_H - 1);
			if (block_end) begin
				r.kind = KIND_BLOCK;
				r.brow = OUT_IDX_W'(brow);
				r.bcol = OUT_IDX_W'(bcol);
				r.sum  = SUM_W'(col_sums[bcol]);
				r.last = !frame_end;
				sums_due.push_back(r);
				col_sums[bcol] = '0;
			end
			if (frame_end) begin
				r.kind = KIND_FRAME;
				r.brow = '0;
				r.bcol = '0;
				r.sum  = frame_sum;
				r.last = 1'b1;
				sums_due.push_back(r);
				frame_sum = '0;
			end
			if (col_pos == FRAME_W - 1) begin
				col_pos = '0;
				row_pos = (row_pos == FRAME_H - 1) ? '0 : row_pos + 1'b1;
			end else begin
				col_pos = col_pos + 1'b1;
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_sum(logic kind, logic [OUT_DATA_W-1:0] data, logic last);
			pixel_sum_t e;
			if (sums_due.size() == 0) begin
				report($sformatf("unexpected result kind %0d data %h last %0d", kind, data, last));
				return;
			end
			e = sums_due.pop_front();
			if (kind !== e.kind || data[ROW_LO +: OUT_IDX_W] !== e.brow ||
					data[COL_LO +: OUT_IDX_W] !== e.bcol || data[SUM_LO +: SUM_W] !== e.sum ||
					last !== e.last || data[OUT_DATA_W-1:PAD_LO] !== '0)
				report($sformatf({"got kind %0d row %0d col %0d sum %0d last %0d pad %h, ",
					"want kind %0d row %0d col %0d sum %0d last %0d"},
					kind, data[ROW_LO +: OUT_IDX_W], data[COL_LO +: OUT_IDX_W],
					data[SUM_LO +: SUM_W], last, data[OUT_DATA_W-1:PAD_LO],
					e.kind, e.brow, e.bcol, e.sum, e.last));
		endtask
	endclass

endpackage

// File: bench/tb_top.sv
// tb_top: drives pixel frames into block_average_downsampler_top and checks every sum
// white frame, random wrapped frame, broken frames and a partial frame, random stalls
// depends on bavg_pkg, bavg_scoreboard_pkg and the design sources
`timescale 1ns / 1ps

module tb_top;
	import bavg_pkg::*;
	import bavg_scoreboard_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN_WAIT = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	block_sum_checker sums;
	bit calm = 1'b0;   // no random idling on either side while set, apart from the one long hold
	int idle_cycles = 0;

	block_average_downsampler_top #(
		.BLOCK_SIZE(BLK_SIZE),
		.BLOCKS_ACROSS(BLK_ACROSS),
		.BLOCKS_DOWN(BLK_DOWN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 0;
		if (r < 97)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tuser  <= frame_start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_sums_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sums.pending() != 0)
			@(posedge clk);
	endtask

	// both sides are sampled at the edge, a request counts when tvalid and tready are high
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sums.accumulate_pixel(s_tdata[PIX_W-1:0], s_tuser);
			if (m_tvalid && m_tready)
				sums.check_sum(m_tuser, m_tdata, m_tlast);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("** block_average_downsampler_top: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// receiver: one long hold-off at the first result so the queue fills, then random stalls
	initial begin
		bit long_hold_done;
		long_hold_done = 1'b0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && m_tvalid) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		int r;
		int c;
		int k;
		int bc;
		logic [PIX_W-1:0] pix;
		sums = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and walking ones, then restarts in mid-frame
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'hAA, 1'b0);
		for (k = 0; k < PIX_W; k++)
			send_pixel(PIX_W'(1 << k), 1'b0);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h7F, 1'b0);
		send_pixel(8'hFE, 1'b1);
		send_pixel(8'h01, 1'b0);

		// all-white frame gives the largest block and frame sums
		for (r = 0; r < FRAME_H; r++) begin
			calm = ($urandom_range(0, 3) == 0);
			for (c = 0; c < FRAME_W; c++)
				send_pixel(8'hFF, r == 0 && c == 0);
		end
		calm = 1'b0;
		wait_sums_drained();

		// next frame follows without a frame start: dark left column, white right column
		for (r = 0; r < FRAME_H; r++) begin
			calm = ($urandom_range(0, 3) == 0);
			for (c = 0; c < FRAME_W; c++) begin
				bc = c / BLK_SIZE;
				if (bc == 0)
					pix = 8'h00;
				else if (bc == BLK_ACROSS - 1)
					pix = 8'hFF;
				else
					pix = PIX_W'($urandom_range(0, 255));
				send_pixel(pix, 1'b0);
			end
		end
		calm = 1'b0;

		// noise with stray frame starts abandoning partial frames
		for (k = 0; k < 1200; k++)
			send_pixel(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 149) == 0);

		// fresh frame after the noise, two block rows deep
		for (k = 0; k < 2 * BLK_SIZE * FRAME_W + BLK_SIZE; k++) begin
			if (k % FRAME_W == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_pixel(PIX_W'($urandom_range(0, 255)), k == 0);
		end
		calm = 1'b0;

		wait_sums_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sums.errors == 0)
			$display("** block_average_downsampler_top: PASSED **");
		else
			$display("** block_average_downsampler_top: FAILED **");
		$finish;
	end

endmodule
